>>> design/bpm_pkg.sv
// Shared types, constants and arithmetic helpers for the backprop neuron unit.
package bpm_pkg;

    localparam int MAX_INPUTS = 64;
    localparam int SLOT_COUNT = MAX_INPUTS + 1;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int QM_W   = PROD_W - 16;

    localparam int EXP_BITS = 20;
    localparam int DIV_Q_W  = 17;
    localparam int DIV_D_W  = 34;

    localparam longint ONE_Q   = 65536;
    localparam longint CLAMP_Q = 45 * ONE_Q;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_ERR  = 2'd2,
        KIND_UPD  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_SIGMOID = 2'd1,
        MODE_STEP    = 2'd2,
        MODE_BIPOLAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RES_OUTPUT = 2'd0,
        RES_ERROR  = 2'd1,
        RES_UPDATE = 2'd2
    } t_rkind;

    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_BETA  = 2'd1,
        CFG_LEARN = 2'd2,
        CFG_MOM   = 2'd3
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE, S_FRD, S_FMUL, S_FACC, S_EMUL, S_EACC,
        S_URD, S_UL, S_UL2, S_UX, S_UC, S_UM, S_UW, S_UWR,
        S_FEND0, S_FEND1, S_FEND2, S_BU, S_LOG0, S_EXP, S_EXPA,
        S_DIVS, S_DIVW, S_FFIN,
        S_EEND0, S_ED1, S_EB1, S_EB2, S_EB3, S_ES, S_ES2, S_EFIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         slot;
        logic signed [31:0] operand;
        logic signed [31:0] link_weight;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [31:0] result_value;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_rsp;

    // e^-(2^k) in Q0.32 for k = -16 .. 3
    function automatic logic [31:0] exp_tab(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'd4294901760;
            5'd1:    v = 32'd4294836226;
            5'd2:    v = 32'd4294705160;
            5'd3:    v = 32'd4294443040;
            5'd4:    v = 32'd4293918848;
            5'd5:    v = 32'd4292870656;
            5'd6:    v = 32'd4290775039;
            5'd7:    v = 32'd4286586875;
            5'd8:    v = 32'd4278222805;
            5'd9:    v = 32'd4261543595;
            5'd10:   v = 32'd4228380000;
            5'd11:   v = 32'd4162825044;
            5'd12:   v = 32'd4034748382;
            5'd13:   v = 32'd3790295335;
            5'd14:   v = 32'd3344923893;
            5'd15:   v = 32'd2605029347;
            5'd16:   v = 32'd1580030169;
            5'd17:   v = 32'd581260615;
            5'd18:   v = 32'd78665070;
            5'd19:   v = 32'd1440801;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sd140737488355327) begin
            r = 48'sh7fffffffffff;
        end else if (v < -64'sd140737488355328) begin
            r = 48'sh800000000000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

>>> design/bpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/bpm_mul.sv
// Shared signed multiplier with a registered product.
module bpm_mul (
    input  logic                                i_clk,
    input  logic signed [bpm_pkg::MUL_W-1:0]    i_a,
    input  logic signed [bpm_pkg::MUL_W-1:0]    i_b,
    output logic signed [bpm_pkg::PROD_W-1:0]   o_p
);
    import bpm_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end
endmodule

>>> design/bpm_div.sv
// Bit-serial restoring divider for the logistic reciprocal, 2^48 / den rounded.
module bpm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpm_pkg::t_div_req i_req,
    output bpm_pkg::t_div_rsp o_rsp
);
    import bpm_pkg::*;

    localparam int REM_W = DIV_D_W + 1;
    localparam int NUM_W = 49;

    logic [REM_W-1:0]   r_rem;
    logic [DIV_Q_W-1:0] r_low;
    logic [DIV_Q_W-1:0] r_quot;
    logic [DIV_D_W-1:0] r_den;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [NUM_W-1:0]   num;
    logic [REM_W-1:0]   trial;
    logic               fits;

    // numerator carries the half-divisor for round to nearest
    assign num   = (NUM_W'(1) << 48) + NUM_W'(i_req.den >> 1);
    assign trial = {r_rem[REM_W-2:0], r_low[DIV_Q_W-1]};
    assign fits  = trial >= REM_W'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= i_req.den;
            r_rem  <= REM_W'(num[NUM_W-1:DIV_Q_W]);
            r_low  <= num[DIV_Q_W-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? trial - REM_W'(r_den) : trial;
            r_low  <= r_low << 1;
            r_quot <= {r_quot[DIV_Q_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

>>> design/neuron_backprop_momentum_unit.sv
// Top level: sequencer and datapath of the backprop neuron with momentum.
//
//  channel   direction  handshake                       payload
//  in        input      i_in_valid / o_in_ready         i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready       o_out_item (t_out_item)
//  cfg       input      i_cfg_we, i_cfg_idx             i_cfg_data (31 bits)
//
// Update items at slot 0 skip the multiply by the operand; forward items at slot 0 or out of
// range and out-of-range update items bypass the multiplier and memory steps.
// A forward run end in sigmoid and bipolar modes, unless clamped, runs the e^-x chain on the
// shared multiplier and then the divider; an error run end adds steps that depend on the mode.
// Reset is synchronous; no clearing pass, the change store uses per-slot valid bits.
// A result waits in the output register; a second one stalls the sequencer until it is free.
module neuron_backprop_momentum_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bpm_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bpm_pkg::t_out_item o_out_item,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [30:0]       i_cfg_data
);
    import bpm_pkg::*;

    t_state r_state, n_state;

    t_mode              r_mode;
    logic [30:0]        r_beta;
    logic [30:0]        r_learn;
    logic [16:0]        r_mom;

    logic signed [47:0] r_sum;
    logic signed [31:0] r_out;
    logic signed [31:0] r_err;
    logic [SLOT_COUNT-1:0] r_cvalid;

    logic [SLOT_W-1:0]  r_addr;
    logic               r_slot_zero;
    logic signed [31:0] r_x;
    logic signed [31:0] r_lw;
    logic               r_last;
    t_rkind             r_rk;
    logic signed [31:0] r_res;
    logic signed [31:0] r_w;
    logic signed [31:0] r_ch;
    logic signed [47:0] r_c0;
    logic signed [31:0] r_c;
    logic signed [48:0] r_pre;
    logic               r_ge;
    logic signed [39:0] r_u;
    logic               r_neg;
    logic [EXP_BITS-1:0] r_mag;
    logic [32:0]        r_r;
    logic [4:0]         r_k;
    logic signed [31:0] r_s;
    logic signed [31:0] r_d;

    logic               r_ovalid;
    t_out_item          r_oitem;

    logic               in_fire;
    logic               in_ok;
    logic               out_free;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [QM_W-1:0]   qm;

    logic               wt_we;
    logic [SLOT_W-1:0]  wt_waddr;
    logic [31:0]        wt_wdata;
    logic [SLOT_W-1:0]  rd_addr;
    logic [31:0]        wt_rdata;
    logic [31:0]        ch_rdata;
    logic               ch_we;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic               clamp_lo, clamp_hi;
    logic signed [39:0] mag40;
    logic               mag_big;
    logic [PROD_W-1:0]  exp_round;
    logic signed [31:0] lg;
    logic signed [31:0] new_w;

    assign in_fire  = i_in_valid && o_in_ready;
    assign in_ok    = 32'(i_in_item.slot) <= 32'(MAX_INPUTS);
    assign out_free = !r_ovalid || i_out_ready;
    assign qm       = prod[PROD_W-1:16];

    assign clamp_lo  = 64'(r_pre) < -CLAMP_Q;
    assign clamp_hi  = 64'(r_pre) > CLAMP_Q;
    assign mag40     = r_u[39] ? -r_u : r_u;
    assign mag_big   = |mag40[39:EXP_BITS];
    assign exp_round = prod + (PROD_W'(1) << 31);
    assign lg        = r_neg ? 32'(ONE_Q) - 32'(div_rsp.quot) : 32'(div_rsp.quot);
    assign new_w     = sat32(64'(r_w) + 64'(r_c));

    bpm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    bpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bpm_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (wt_rdata)
    );

    bpm_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_change_ram (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (r_addr),
        .i_wdata (r_c),
        .i_raddr (rd_addr),
        .o_rdata (ch_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_item.kind)
                        KIND_FWD: begin
                            if (in_ok && i_in_item.slot != 7'd0) begin
                                n_state = S_FRD;
                            end else if (i_in_item.last) begin
                                n_state = S_FEND0;
                            end
                        end
                        KIND_ERR: n_state = S_EMUL;
                        KIND_UPD: begin
                            if (in_ok) begin
                                n_state = S_URD;
                            end else if (i_in_item.last) begin
                                n_state = S_EMIT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FRD:   n_state = S_FMUL;
            S_FMUL:  n_state = S_FACC;
            S_FACC:  n_state = r_last ? S_FEND0 : S_IDLE;
            S_EMUL:  n_state = S_EACC;
            S_EACC:  n_state = r_last ? S_EEND0 : S_IDLE;
            S_URD:   n_state = S_UL;
            S_UL:    n_state = S_UL2;
            S_UL2:   n_state = r_slot_zero ? S_UM : S_UX;
            S_UX:    n_state = S_UC;
            S_UC:    n_state = S_UM;
            S_UM:    n_state = S_UW;
            S_UW:    n_state = S_UWR;
            S_UWR:   n_state = r_last ? S_EMIT : S_IDLE;
            S_FEND0: n_state = S_FEND1;
            S_FEND1: n_state = S_FEND2;
            S_FEND2: begin
                case (r_mode)
                    MODE_SIGMOID: n_state = (clamp_lo || clamp_hi) ? S_FFIN : S_LOG0;
                    MODE_BIPOLAR: n_state = (clamp_lo || clamp_hi) ? S_FFIN : S_BU;
                    default:      n_state = S_FFIN;
                endcase
            end
            S_BU:    n_state = S_LOG0;
            S_LOG0:  n_state = mag_big ? S_DIVS : S_EXP;
            S_EXP: begin
                if (r_mag[r_k]) begin
                    n_state = S_EXPA;
                end else if (r_k == 5'(EXP_BITS - 1)) begin
                    n_state = S_DIVS;
                end
            end
            S_EXPA:  n_state = (r_k == 5'(EXP_BITS - 1)) ? S_DIVS : S_EXP;
            S_DIVS:  n_state = S_DIVW;
            S_DIVW:  n_state = div_rsp.done ? S_FFIN : S_DIVW;
            S_FFIN:  n_state = S_EMIT;
            S_EEND0: begin
                case (r_mode)
                    MODE_SIGMOID: n_state = S_ED1;
                    MODE_BIPOLAR: n_state = S_EB1;
                    default:      n_state = S_EFIN;
                endcase
            end
            S_ED1:   n_state = S_ES;
            S_EB1:   n_state = S_EB2;
            S_EB2:   n_state = S_EB3;
            S_EB3:   n_state = S_ES;
            S_ES:    n_state = S_ES2;
            S_ES2:   n_state = S_EFIN;
            S_EFIN:  n_state = S_EMIT;
            S_EMIT:  n_state = out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // unit controls: multiplier operands, memory ports, divider start
    always_comb begin
        o_in_ready  = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        wt_we       = 1'b0;
        wt_waddr    = r_addr;
        wt_wdata    = new_w;
        ch_we       = 1'b0;
        rd_addr     = r_addr;
        div_req.start = 1'b0;
        div_req.den   = DIV_D_W'(34'h1_0000_0000) + DIV_D_W'(r_r);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                wt_we      = in_fire && i_in_item.kind == KIND_LOAD && in_ok;
                wt_waddr   = SLOT_W'(i_in_item.slot);
                wt_wdata   = i_in_item.operand;
            end
            S_FMUL: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'($signed(wt_rdata));
            end
            S_EMUL: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'(r_lw);
            end
            S_UL: begin
                mul_a = MUL_W'({1'b0, r_learn});
                mul_b = MUL_W'(r_err);
            end
            S_UX: begin
                mul_a = MUL_W'($signed(r_c0[31:0]));
                mul_b = MUL_W'(r_x);
            end
            S_UM: begin
                mul_a = MUL_W'({1'b0, r_mom});
                mul_b = MUL_W'(r_ch);
            end
            S_UWR: begin
                wt_we = 1'b1;
                ch_we = 1'b1;
            end
            S_FEND0: rd_addr = '0;
            S_FEND2: begin
                mul_a = MUL_W'({1'b0, r_beta});
                mul_b = r_pre[MUL_W-1:0];
            end
            S_EXP: begin
                mul_a = MUL_W'({1'b0, r_r});
                mul_b = MUL_W'({1'b0, exp_tab(r_k)});
            end
            S_DIVS: div_req.start = 1'b1;
            S_EEND0: begin
                mul_a = MUL_W'(r_out);
                mul_b = (r_mode == MODE_BIPOLAR) ? MUL_W'(r_out)
                                                 : MUL_W'(ONE_Q) - MUL_W'(r_out);
            end
            S_EB2: begin
                mul_a = MUL_W'({1'b0, r_beta});
                mul_b = MUL_W'(r_d);
            end
            S_ES: begin
                mul_a = MUL_W'(r_s);
                mul_b = MUL_W'(r_d);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_LINEAR;
            r_beta   <= 31'd65536;
            r_learn  <= 31'd6554;
            r_mom    <= '0;
            r_sum    <= '0;
            r_out    <= '0;
            r_err    <= '0;
            r_cvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[1:0]);
                    CFG_BETA:  r_beta  <= i_cfg_data;
                    CFG_LEARN: r_learn <= i_cfg_data;
                    CFG_MOM:   r_mom   <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_FACC, S_EACC: r_sum <= sat48(64'(r_sum) + 64'(qm));
                S_FFIN: begin
                    r_out <= r_res;
                    r_sum <= '0;
                end
                S_EFIN: begin
                    r_err <= r_res;
                    r_sum <= '0;
                end
                S_UWR:  r_cvalid[r_addr] <= 1'b1;
                default: ;
            endcase
            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_addr      <= SLOT_W'(i_in_item.slot);
                    r_slot_zero <= i_in_item.slot == 7'd0;
                    r_x         <= i_in_item.operand;
                    r_lw        <= i_in_item.link_weight;
                    r_last      <= i_in_item.last;
                    r_res       <= '0;
                    case (i_in_item.kind)
                        KIND_FWD: r_rk <= RES_OUTPUT;
                        KIND_ERR: r_rk <= RES_ERROR;
                        default:  r_rk <= RES_UPDATE;
                    endcase
                end
            end
            S_UL: begin
                r_w  <= $signed(wt_rdata);
                r_ch <= r_cvalid[r_addr] ? $signed(ch_rdata) : 32'sd0;
            end
            S_UL2: r_c0 <= 48'(sat32(64'(qm)));
            S_UC:  r_c0 <= 48'(qm);
            S_UW:  r_c  <= sat32(64'(r_c0) + 64'(qm));
            S_UWR: r_res <= new_w;
            S_FEND1: begin
                r_w   <= $signed(wt_rdata);
                r_pre <= 49'(r_sum) + 49'($signed(wt_rdata));
                r_ge  <= 64'(r_sum) >= 64'($signed(wt_rdata));
            end
            S_FEND2: begin
                r_u <= 40'(r_pre);
                case (r_mode)
                    MODE_LINEAR: r_res <= sat32(64'(r_pre));
                    MODE_STEP:   r_res <= r_ge ? 32'(ONE_Q) : 32'sd0;
                    MODE_SIGMOID: begin
                        if (clamp_lo) r_res <= 32'sd0;
                        else if (clamp_hi) r_res <= 32'(ONE_Q);
                    end
                    default: begin
                        if (clamp_lo) r_res <= -32'(ONE_Q);
                        else if (clamp_hi) r_res <= 32'(ONE_Q);
                    end
                endcase
            end
            S_BU: r_u <= qm[39:0];
            S_LOG0: begin
                r_neg <= r_u[39];
                r_mag <= mag40[EXP_BITS-1:0];
                r_r   <= mag_big ? 33'd0 : 33'h1_0000_0000;
                r_k   <= '0;
            end
            S_EXP: begin
                if (!r_mag[r_k]) r_k <= r_k + 5'd1;
            end
            S_EXPA: begin
                r_r <= exp_round[64:32];
                r_k <= r_k + 5'd1;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    r_res <= (r_mode == MODE_BIPOLAR) ? (lg <<< 1) - 32'(ONE_Q) : lg;
                end
            end
            S_EEND0: begin
                r_s   <= sat32(64'(r_sum));
                r_res <= sat32(64'(r_sum));
            end
            S_ED1: r_d <= sat32(64'(qm));
            S_EB1: r_d <= sat32(64'(ONE_Q) - 64'(qm));
            S_EB3: r_d <= sat32(64'($signed(prod[PROD_W-1:17])));
            S_ES2: r_res <= sat32(64'(qm));
            S_EMIT: begin
                if (out_free) begin
                    r_oitem.result_kind  <= r_rk;
                    r_oitem.result_value <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

`ifndef NO_ASSERTIONS
    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_state != S_IDLE |=> !o_in_ready)
        else $error("ready while an item is still in work");
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && out_free |=> o_out_valid)
        else $error("result not presented after emit");
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FFIN || r_state == S_EFIN |=> r_sum == 48'sd0)
        else $error("accumulator not cleared at run end");
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> div_rsp.quot <= 17'h10000)
        else $error("logistic quotient above one");
`endif
endmodule

>>> bench/tb_neuron_backprop_momentum_unit.sv
// Self-checking bench for the backprop neuron with momentum: directed table, random runs.
`timescale 1ns / 1ps

module tb_neuron_backprop_momentum_unit;
    import bpm_pkg::*;

    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint S48_HI = 64'sd140737488355327;
    localparam longint S48_LO = -64'sd140737488355328;
    localparam longint UNIT   = 64'sd65536;
    localparam longint SPAN   = 45 * 64'sd65536;
    localparam int     PHASES = 14;
    localparam int     PER_PHASE = 100;

    // e^-(2^k) in Q0.32, k = -16 .. 3
    localparam logic [31:0] EXP_NEG [20] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
        32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
        32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
        32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    logic      cfg_we;
    logic [1:0]  cfg_idx;
    logic [30:0] cfg_data;

    // typed expectation that travels with the item on the input channel
    logic      row_typed;
    t_out_item row_result;

    neuron_backprop_momentum_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // neuron state mirror
    longint wt_mem [SLOT_COUNT];
    longint chg_mem [SLOT_COUNT];
    longint acc48, node_out, node_err;
    t_mode  act_mode;
    longint beta_q, rate_q, mom_q;

    t_out_item pending_results [$];
    int  fail_count, mismatch_count, transfers_in, results_seen;
    bit  idling_on, hold_request;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_w(longint v);
        return clip(v, S32_LO, S32_HI);
    endfunction

    function automatic longint qmul_q(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint logistic_q(longint u);
        longint mag;
        logic [127:0] r, den, s;
        mag = u < 0 ? -u : u;
        r = '0;
        if (mag < 16 * UNIT) begin
            r = 128'd1 << 32;
            for (int k = 0; k < 20; k++)
                if (mag[k]) r = (r * EXP_NEG[k] + (128'd1 << 31)) >> 32;
        end
        den = (128'd1 << 32) + r;
        s = ((128'd1 << 48) + (den >> 1)) / den;
        return u < 0 ? UNIT - longint'(s[63:0]) : longint'(s[63:0]);
    endfunction

    function automatic longint activate_sum();
        longint pre;
        pre = wt_mem[0] + acc48;
        case (act_mode)
            MODE_SIGMOID: begin
                if (pre < -SPAN) return 0;
                if (pre > SPAN) return UNIT;
                return logistic_q(pre);
            end
            MODE_STEP: return acc48 >= wt_mem[0] ? UNIT : 0;
            MODE_BIPOLAR: begin
                if (pre < -SPAN) return -UNIT;
                if (pre > SPAN) return UNIT;
                return 2 * logistic_q(qmul_q(beta_q, pre)) - UNIT;
            end
            default: return sat_w(pre);
        endcase
    endfunction

    function automatic longint scale_error();
        longint s, d;
        s = sat_w(acc48);
        if (act_mode == MODE_SIGMOID) begin
            d = sat_w(qmul_q(node_out, UNIT - node_out));
        end else if (act_mode == MODE_BIPOLAR) begin
            d = sat_w(UNIT - qmul_q(node_out, node_out));
            d = sat_w((beta_q * d) >>> 17);
        end else begin
            return s;
        end
        return sat_w(qmul_q(s, d));
    endfunction

    // advance the mirror by one item; returns 1 when the item yields a result
    function automatic bit neuron_step(input t_in_item it, output t_out_item res);
        longint x, lw, val, lte, c;
        int  sl;
        bit  ok;
        x = it.operand;
        lw = it.link_weight;
        sl = int'(it.slot);
        ok = sl <= MAX_INPUTS;
        val = 0;
        res = '0;
        case (t_kind'(it.kind))
            KIND_LOAD: begin
                if (ok) wt_mem[sl] = x;
                return 0;
            end
            KIND_FWD: begin
                if (ok && sl > 0) acc48 = clip(acc48 + qmul_q(x, wt_mem[sl]), S48_LO, S48_HI);
                if (!it.last) return 0;
                node_out = activate_sum();
                acc48 = 0;
                res.result_kind = RES_OUTPUT;
                res.result_value = node_out[31:0];
            end
            KIND_ERR: begin
                acc48 = clip(acc48 + qmul_q(x, lw), S48_LO, S48_HI);
                if (!it.last) return 0;
                node_err = scale_error();
                acc48 = 0;
                res.result_kind = RES_ERROR;
                res.result_value = node_err[31:0];
            end
            default: begin
                if (ok) begin
                    lte = sat_w(qmul_q(rate_q, node_err));
                    c = sl != 0 ? qmul_q(lte, x) : lte;
                    c = sat_w(c + qmul_q(mom_q, chg_mem[sl]));
                    wt_mem[sl] = sat_w(wt_mem[sl] + c);
                    chg_mem[sl] = c;
                    val = wt_mem[sl];
                end
                if (!it.last) return 0;
                res.result_kind = RES_UPDATE;
                res.result_value = val[31:0];
            end
        endcase
        return 1;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL neuron_backprop_momentum_unit");
        $finish;
    end

    // predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                transfers_in++;
                if (neuron_step(in_item, want)) begin
                    if (row_typed) want = row_result;
                    pending_results.push_back(want);
                end
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result kind=%0d value=%h",
                                 out_item.result_kind, out_item.result_value);
                end else begin
                    want = pending_results.pop_front();
                    if (out_item.result_kind !== want.result_kind ||
                        out_item.result_value !== want.result_value) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: kind exp %0d got %0d, value exp %h got %h",
                                     want.result_kind, out_item.result_kind,
                                     want.result_value, out_item.result_value);
                    end
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                n = 0;
                while (n < 300) begin
                    @(negedge i_clk);
                    n++;
                end
                hold_request = 0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item tr);
        if (idling_on && $urandom_range(0, 6) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        in_item    <= it;
        row_typed  <= typed;
        row_result <= tr;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_plain(input t_in_item it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input t_cfg_idx idx, input logic [30:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MODE:  act_mode = t_mode'(val[1:0]);
            CFG_BETA:  beta_q = val;
            CFG_LEARN: rate_q = val;
            default:   mom_q = val[16:0];
        endcase
        @(negedge i_clk);
    endtask

    function automatic t_in_item make_item(t_kind k, int sl, logic [31:0] op,
                                           logic [31:0] lw, bit lst);
        t_in_item it;
        it.kind = k;
        it.slot = sl[6:0];
        it.operand = op;
        it.link_weight = lw;
        it.last = lst;
        return it;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(0, 32'h40000) - 32'h20000;
        endcase
    endfunction

    function automatic int rand_slot();
        return $urandom_range(0, 15) == 0 ? $urandom_range(MAX_INPUTS + 1, 127)
                                          : $urandom_range(0, MAX_INPUTS);
    endfunction

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item tr;
    } t_row;

    t_row stim_rows [$];

    function automatic void add_row(t_kind k, int sl, logic [31:0] op, logic [31:0] lw,
                                    bit lst, bit typed, t_rkind rk, logic [31:0] rv);
        t_row r;
        r.it = make_item(k, sl, op, lw, lst);
        r.typed = typed;
        r.tr.result_kind = rk;
        r.tr.result_value = rv;
        stim_rows.push_back(r);
    endfunction

    initial begin
        int sent, len, phase;
        logic [30:0] mode_v, beta_v, rate_v, mom_v;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        row_typed = 1'b0;
        row_result = '0;
        cfg_we = 1'b0;
        cfg_idx = CFG_MODE;
        cfg_data = '0;
        fail_count = 0;
        mismatch_count = 0;
        transfers_in = 0;
        results_seen = 0;
        idling_on = 1;
        hold_request = 0;
        foreach (wt_mem[i]) begin
            wt_mem[i] = 0;
            chg_mem[i] = 0;
        end
        acc48 = 0;
        node_out = 0;
        node_err = 0;
        act_mode = MODE_LINEAR;
        beta_q = 65536;
        rate_q = 6554;
        mom_q = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // give every slot a weight so no read hits an unwritten entry
        for (int s = 0; s <= MAX_INPUTS; s++)
            send_plain(make_item(KIND_LOAD, s, rand_q(), $urandom, 1'($urandom_range(0, 1))));

        add_row(KIND_LOAD, 0, 32'h00010000, 0, 0, 0, RES_OUTPUT, 0);
        add_row(KIND_LOAD, 1, 32'h00020000, 0, 0, 0, RES_OUTPUT, 0);
        add_row(KIND_FWD, 1, 32'h00030000, 0, 1, 1, RES_OUTPUT, 32'h00070000);
        add_row(KIND_FWD, 0, 32'h12345678, 0, 1, 1, RES_OUTPUT, 32'h00010000);
        add_row(KIND_FWD, 100, 32'h7fffffff, 0, 1, 1, RES_OUTPUT, 32'h00010000);
        add_row(KIND_ERR, 0, 32'h00010000, 32'h00020000, 1, 1, RES_ERROR, 32'h00020000);
        add_row(KIND_LOAD, 64, 32'h7fffffff, 0, 0, 0, RES_OUTPUT, 0);
        add_row(KIND_FWD, 64, 32'h7fffffff, 0, 0, 0, RES_OUTPUT, 0);
        add_row(KIND_FWD, 64, 32'h7fffffff, 0, 1, 1, RES_OUTPUT, 32'h7fffffff);
        add_row(KIND_LOAD, 64, 32'h80000000, 0, 0, 0, RES_OUTPUT, 0);
        add_row(KIND_FWD, 64, 32'h7fffffff, 0, 0, 0, RES_OUTPUT, 0);
        add_row(KIND_FWD, 64, 32'h7fffffff, 0, 1, 1, RES_OUTPUT, 32'h80000000);
        add_row(KIND_LOAD, 0, 32'h00010000, 32'hffffffff, 1, 0, RES_OUTPUT, 0);
        add_row(KIND_ERR, 5, 32'h80000000, 32'h80000000, 1, 1, RES_ERROR, 32'h7fffffff);
        add_row(KIND_UPD, 1, 32'h00010000, 0, 1, 0, RES_UPDATE, 0);
        add_row(KIND_UPD, 127, 32'hffffffff, 0, 1, 1, RES_UPDATE, 32'h00000000);
        add_row(KIND_FWD, 1, 32'h00010000, 0, 0, 0, RES_OUTPUT, 0);
        add_row(KIND_ERR, 0, 32'h00010000, 32'h00010000, 1, 0, RES_ERROR, 0);
        add_row(KIND_UPD, 0, 32'h00000000, 0, 1, 0, RES_UPDATE, 0);
        add_row(KIND_LOAD, 127, 32'h55555555, 0, 1, 0, RES_OUTPUT, 0);
        add_row(KIND_FWD, 1, 32'h00010000, 0, 1, 0, RES_OUTPUT, 0);
        foreach (stim_rows[i]) send_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].tr);

        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin mode_v = 31'(MODE_SIGMOID); beta_v = 65536; rate_v = 65536;
                         mom_v = 32768; end
                1: begin mode_v = 31'(MODE_STEP); beta_v = 0; rate_v = 0; mom_v = 65536; end
                2: begin mode_v = 31'(MODE_BIPOLAR); beta_v = 31'h7fffffff;
                         rate_v = 31'h7fffffff; mom_v = 65536; end
                3: begin mode_v = 31'(MODE_BIPOLAR); beta_v = 0; rate_v = 6554; mom_v = 0; end
                4: begin mode_v = 31'(MODE_LINEAR); beta_v = 131072; rate_v = 31'h7fffffff;
                         mom_v = 0; end
                default: begin
                    mode_v = 31'($urandom_range(0, 3));
                    beta_v = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                       : 31'($urandom_range(0, 262144));
                    rate_v = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                       : 31'($urandom_range(0, 131072));
                    mom_v = 31'($urandom_range(0, 65536));
                end
            endcase
            write_reg(CFG_MODE, mode_v);
            write_reg(CFG_BETA, beta_v);
            write_reg(CFG_LEARN, rate_v);
            write_reg(CFG_MOM, mom_v);
            cfg_we <= 1'b0;
            if (phase == 2) hold_request = 1;
            if (phase >= PHASES - 2) idling_on = 0;
            sent = 0;
            while (sent < PER_PHASE) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        len = $urandom_range(1, 6);
                        for (int j = 0; j < len; j++)
                            send_plain(make_item(KIND_FWD, rand_slot(), rand_q(), $urandom,
                                                 j == len - 1));
                        sent += len;
                    end
                    3, 4: begin
                        len = $urandom_range(1, 4);
                        for (int j = 0; j < len; j++)
                            send_plain(make_item(KIND_ERR, rand_slot(), rand_q(), rand_q(),
                                                 j == len - 1));
                        sent += len;
                    end
                    5, 6: begin
                        len = $urandom_range(1, 5);
                        for (int j = 0; j < len; j++)
                            send_plain(make_item(KIND_UPD, rand_slot(), rand_q(), $urandom,
                                                 j == len - 1));
                        sent += len;
                    end
                    7: begin
                        send_plain(make_item(KIND_LOAD, rand_slot(), rand_q(), $urandom,
                                             1'($urandom_range(0, 1))));
                        sent++;
                    end
                    default: begin
                        // noise: any kind, any slot, any last flag
                        send_plain(make_item(t_kind'($urandom_range(0, 3)),
                                             $urandom_range(0, 127), $urandom, $urandom,
                                             1'($urandom_range(0, 1))));
                        sent++;
                    end
                endcase
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        $display("Covered %0d input transfers and %0d results over %0d settings of the four",
                 transfers_in, results_seen, PHASES + 1);
        $display("registers, all activation modes, one long output stall; %0d mismatches.",
                 mismatch_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS neuron_backprop_momentum_unit");
        end else begin
            $display("FAIL neuron_backprop_momentum_unit");
        end
        $finish;
    end

endmodule
